>>> design/ws2812_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ws2812_pkg
// Shared item types, command codes, register indexes and the gamma table.
// ----------------------------------------------------------------------------
package ws2812_pkg;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_BYTE = 1'b1;

	localparam logic [1:0] REG_ONE_HIGH  = 2'd0;
	localparam logic [1:0] REG_ZERO_HIGH = 2'd1;
	localparam logic [1:0] REG_PERIOD    = 2'd2;
	localparam logic [1:0] REG_GAMMA_EN  = 2'd3;

	localparam int CFG_BITS = 16;

	typedef struct packed {
		logic       cmd;
		logic [7:0] pixel_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic data_line;
		logic accept_ready;
		logic frame_done;
		logic underrun;
		logic busy_res;
	} out_item_t;

	localparam logic [7:0] GAMMA_ROM [256] = '{
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2,
		8'd2, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3,
		8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd5, 8'd5, 8'd5,
		8'd5, 8'd6, 8'd6, 8'd6, 8'd6, 8'd7, 8'd7, 8'd7,
		8'd7, 8'd8, 8'd8, 8'd8, 8'd9, 8'd9, 8'd9, 8'd10,
		8'd10, 8'd10, 8'd11, 8'd11, 8'd11, 8'd12, 8'd12, 8'd13,
		8'd13, 8'd13, 8'd14, 8'd14, 8'd15, 8'd15, 8'd16, 8'd16,
		8'd17, 8'd17, 8'd18, 8'd18, 8'd19, 8'd19, 8'd20, 8'd20,
		8'd21, 8'd21, 8'd22, 8'd22, 8'd23, 8'd24, 8'd24, 8'd25,
		8'd25, 8'd26, 8'd27, 8'd27, 8'd28, 8'd29, 8'd29, 8'd30,
		8'd31, 8'd32, 8'd32, 8'd33, 8'd34, 8'd35, 8'd35, 8'd36,
		8'd37, 8'd38, 8'd39, 8'd39, 8'd40, 8'd41, 8'd42, 8'd43,
		8'd44, 8'd45, 8'd46, 8'd47, 8'd48, 8'd49, 8'd50, 8'd50,
		8'd51, 8'd52, 8'd54, 8'd55, 8'd56, 8'd57, 8'd58, 8'd59,
		8'd60, 8'd61, 8'd62, 8'd63, 8'd64, 8'd66, 8'd67, 8'd68,
		8'd69, 8'd70, 8'd72, 8'd73, 8'd74, 8'd75, 8'd77, 8'd78,
		8'd79, 8'd81, 8'd82, 8'd83, 8'd85, 8'd86, 8'd87, 8'd89,
		8'd90, 8'd92, 8'd93, 8'd95, 8'd96, 8'd98, 8'd99, 8'd101,
		8'd102, 8'd104, 8'd105, 8'd107, 8'd109, 8'd110, 8'd112, 8'd114,
		8'd115, 8'd117, 8'd119, 8'd120, 8'd122, 8'd124, 8'd126, 8'd127,
		8'd129, 8'd131, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140, 8'd142,
		8'd144, 8'd146, 8'd148, 8'd150, 8'd152, 8'd154, 8'd156, 8'd158,
		8'd160, 8'd162, 8'd164, 8'd167, 8'd169, 8'd171, 8'd173, 8'd175,
		8'd177, 8'd180, 8'd182, 8'd184, 8'd186, 8'd189, 8'd191, 8'd193,
		8'd196, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213,
		8'd215, 8'd218, 8'd220, 8'd223, 8'd225, 8'd228, 8'd231, 8'd233,
		8'd236, 8'd239, 8'd241, 8'd244, 8'd247, 8'd249, 8'd252, 8'd255
	};

endpackage
`default_nettype wire

>>> design/ws2812_gamma_serializer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ws2812_gamma_serializer
// One-wire LED data line serializer with optional gamma mapping.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while in_stall is low: a tick advances line
// timing by one step, a byte item fills the one-entry holding buffer if it is
// empty. Each item passes an input register and then a result register; a
// stalled result does not hold up input until both registers are full. Bytes
// go out MSB first, optionally through the gamma table at the moment they
// enter the shifter.
module ws2812_gamma_serializer
	import ws2812_pkg::*;
#(
	parameter int TIMER_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire in_item_t            in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output out_item_t                out_data,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [CFG_BITS-1:0] cfg_data
);

	localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

	logic [CFG_BITS-1:0] one_high_q, zero_high_q, period_q;
	logic                gamma_en_q;

	logic                  s1_valid;
	in_item_t              item_s1;
	logic                  out_valid_q;
	out_item_t             out_data_q;
	logic                  out_free, s1_go;

	logic [7:0]            shift_q, shift_d;
	logic [3:0]            bits_q, bits_d;
	logic [TIMER_BITS-1:0] timer_q, timer_d;
	logic [7:0]            held_q, held_d;
	logic                  held_valid_q, held_valid_d;
	logic                  held_last_q, held_last_d;
	logic                  sending_last_q, sending_last_d;
	logic                  active_q, active_d;
	logic                  trailing_q, trailing_d;

	logic [TIMER_BITS-1:0] period, one_high, zero_high, high_sel, t_inc;
	logic [TIMER_BITS:0]   t_wide;
	logic                  load, done, under, level;

	function automatic logic [TIMER_BITS-1:0] sat(input logic [CFG_BITS-1:0] v);
		logic [32:0] w;
		w = {{(33-CFG_BITS){1'b0}}, v};
		if (w > TIMER_MAX)
			sat = TIMER_MAX[TIMER_BITS-1:0];
		else
			sat = w[TIMER_BITS-1:0];
	endfunction

	assign period    = sat(period_q);
	assign one_high  = sat(one_high_q);
	assign zero_high = sat(zero_high_q);
	assign t_wide    = {1'b0, timer_q} + {{TIMER_BITS{1'b0}}, 1'b1};
	assign t_inc     = t_wide[TIMER_BITS] ? TIMER_MAX[TIMER_BITS-1:0] : t_wide[TIMER_BITS-1:0];

	assign out_free  = !out_valid_q || !out_stall;
	assign s1_go     = s1_valid && out_free;
	assign in_stall  = s1_valid && !out_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_high_q <= 16'd96;
			zero_high_q <= 16'd40;
			period_q <= 16'd200;
			gamma_en_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ONE_HIGH:  one_high_q <= cfg_data;
				REG_ZERO_HIGH: zero_high_q <= cfg_data;
				REG_PERIOD:    period_q <= cfg_data;
				REG_GAMMA_EN:  gamma_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		shift_d        = shift_q;
		bits_d         = bits_q;
		timer_d        = timer_q;
		held_d         = held_q;
		held_valid_d   = held_valid_q;
		held_last_d    = held_last_q;
		sending_last_d = sending_last_q;
		active_d       = active_q;
		trailing_d     = trailing_q;
		load           = 1'b0;
		done           = 1'b0;
		under          = 1'b0;

		if (item_s1.cmd == CMD_BYTE) begin
			if (!held_valid_q) begin
				held_d       = item_s1.pixel_byte;
				held_last_d  = item_s1.last_byte;
				held_valid_d = 1'b1;
			end
		end else if (!active_q) begin
			if (held_valid_q) begin
				load       = 1'b1;
				active_d   = 1'b1;
				trailing_d = 1'b0;
			end
		end else if (trailing_q) begin
			if (t_inc >= period) begin
				done           = 1'b1;
				active_d       = 1'b0;
				trailing_d     = 1'b0;
				sending_last_d = 1'b0;
				timer_d        = '0;
			end else begin
				timer_d = t_inc;
			end
		end else if (bits_q == 4'd0) begin
			if (held_valid_q)
				load = 1'b1;
			else
				under = 1'b1;
		end else begin
			if (t_inc >= period) begin
				shift_d = {shift_q[6:0], 1'b0};
				bits_d  = bits_q - 4'd1;
				timer_d = '0;
				if (bits_q == 4'd1) begin
					if (sending_last_q)
						trailing_d = 1'b1;
					else if (held_valid_q)
						load = 1'b1;
					else
						under = 1'b1;
				end
			end else begin
				timer_d = t_inc;
			end
		end

		if (load) begin
			shift_d        = gamma_en_q ? GAMMA_ROM[held_q] : held_q;
			bits_d         = 4'd8;
			sending_last_d = held_last_q;
			held_valid_d   = 1'b0;
			timer_d        = '0;
		end

		high_sel = shift_d[7] ? one_high : zero_high;
		level    = active_d && !trailing_d && (bits_d != 4'd0) && (timer_d < high_sel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid       <= 1'b0;
			out_valid_q    <= 1'b0;
			shift_q        <= '0;
			bits_q         <= '0;
			timer_q        <= '0;
			held_q         <= '0;
			held_valid_q   <= 1'b0;
			held_last_q    <= 1'b0;
			sending_last_q <= 1'b0;
			active_q       <= 1'b0;
			trailing_q     <= 1'b0;
		end else begin
			if (!in_stall)
				s1_valid <= in_valid;
			if (out_free)
				out_valid_q <= s1_valid;
			if (s1_go) begin
				shift_q        <= shift_d;
				bits_q         <= bits_d;
				timer_q        <= timer_d;
				held_q         <= held_d;
				held_valid_q   <= held_valid_d;
				held_last_q    <= held_last_d;
				sending_last_q <= sending_last_d;
				active_q       <= active_d;
				trailing_q     <= trailing_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= in_data;
		if (s1_go) begin
			out_data_q.data_line    <= level;
			out_data_q.accept_ready <= !held_valid_d;
			out_data_q.frame_done   <= done;
			out_data_q.underrun     <= under;
			out_data_q.busy_res     <= active_d;
		end
	end

endmodule
`default_nettype wire
